@@ sv/kpdcd_pkg.sv @@
package kpdcd_pkg;

  localparam int COLOR_CLASSES  = 4;
  localparam int NUMBER_CLASSES = 10;
  localparam int POINT_VALUES   = 8;
  localparam int SCORE_POS      = 8;
  localparam int COLOR_POS      = 9;
  localparam int NUMBER_POS     = COLOR_POS + COLOR_CLASSES;
  localparam int ROW_LENGTH     = NUMBER_POS + NUMBER_CLASSES;

  localparam int POS_W  = $clog2(ROW_LENGTH);
  localparam int CIDX_W = $clog2(COLOR_CLASSES);
  localparam int NIDX_W = 4;
  localparam int ADDR_W = 5;
  localparam int PROD_W = 56;
  localparam int DATA_W = 264;

  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t LAST_POS = POS_W'(ROW_LENGTH - 1);

  // register index, byte address divided by four
  typedef enum logic [2:0] {
    REG_SCORE_THRESHOLD = 3'd0,
    REG_SELECT_BLUE     = 3'd1,
    REG_OFFSET_X        = 3'd2,
    REG_OFFSET_Y        = 3'd3,
    REG_INVERSE_SCALE   = 3'd4
  } reg_index_t;

endpackage

@@ sv/keypoint_detection_candidate_decoder_core.sv @@
// channel   direction  handshake                 payload
// s_*       in         s_tvalid / s_tready       s_tdata value, s_tlast frame_last
// m_*       out        m_tvalid / m_tready       m_tdata result, m_tuser point_index,
//                                                m_tlast last of candidate
// apb       in         psel, penable, pready     five config registers at 4*i
//
// one item is accepted per cycle while s_tready is high; each item goes through an
// input register, a 32x24 product register and a decode/update stage, and the four
// results of a kept candidate go out one per cycle while m_tready is high.
// s_tready drops only on a row's final value while the previous candidate's
// results still wait in the result buffer.
// rst is synchronous and clears the row position, pipeline valids and registers.
module keypoint_detection_candidate_decoder_core
  import kpdcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [31:0]       s_tdata,   // value[31:0]
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  // point_x[31:0], point_y[63:32], score[95:64], color_class[96],
  // number_class[100:97], number_score[132:101], box_left[164:133],
  // box_top[196:165], box_right[228:197], box_bottom[260:229], zero pad
  output logic [DATA_W-1:0] m_tdata,
  output logic [1:0]        m_tuser,   // point_index[1:0]
  output logic              m_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [16:0] score_threshold;
  logic        select_blue;
  logic [27:0] offset_x;
  logic [27:0] offset_y;
  logic [23:0] inverse_scale;

  pos_t        row_pos;
  logic        accept;

  logic        s1_valid;
  pos_t        s1_pos;
  logic [31:0] s1_value;
  logic [32:0] s1_diff;
  logic        s1_neg;
  logic [31:0] s1_mag;
  logic [PROD_W-1:0] s1_prod;

  logic        s2_valid;
  pos_t        s2_pos;
  logic [31:0] s2_value;
  logic        s2_neg;
  logic [PROD_W-1:0] s2_prod;
  logic [39:0] s2_p;
  logic [31:0] coord;
  logic        is_y;

  logic [31:0] point_store [POINT_VALUES];
  logic [31:0] box_left, box_top, box_right, box_bottom;
  logic [31:0] candidate_score;
  logic [31:0] best_color_score;
  logic [CIDX_W-1:0] best_color_index;
  logic [31:0] best_number_score;
  logic [NIDX_W-1:0] best_number_index;

  logic        color_zone, color_take;
  logic        number_zone, number_take;
  logic [31:0] number_score_next;
  logic [NIDX_W-1:0] number_index_next;
  logic        row_end, keep;

  logic [31:0] o_pt [POINT_VALUES];
  logic [31:0] o_left, o_top, o_right, o_bottom;
  logic [31:0] o_score, o_nscore;
  logic        o_color;
  logic [NIDX_W-1:0] o_nclass;
  logic        out_busy;
  logic [1:0]  out_idx;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      score_threshold <= 17'd32768;
      select_blue     <= 1'b0;
      offset_x        <= '0;
      offset_y        <= '0;
      inverse_scale   <= 24'd65536;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        REG_SCORE_THRESHOLD: score_threshold <= pwdata[16:0];
        REG_SELECT_BLUE:     select_blue     <= pwdata[0];
        REG_OFFSET_X:        offset_x        <= pwdata[27:0];
        REG_OFFSET_Y:        offset_y        <= pwdata[27:0];
        REG_INVERSE_SCALE:   inverse_scale   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SCORE_THRESHOLD: prdata = {15'd0, score_threshold};
      REG_SELECT_BLUE:     prdata = {31'd0, select_blue};
      REG_OFFSET_X:        prdata = {4'd0, offset_x};
      REG_OFFSET_Y:        prdata = {4'd0, offset_y};
      REG_INVERSE_SCALE:   prdata = {8'd0, inverse_scale};
      default:             prdata = '0;
    endcase
  end

  // input side: the row's final value waits only while the result buffer is full
  assign s_tready = !(row_pos == LAST_POS && out_busy);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos  <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (s_tlast || row_pos == LAST_POS) begin
          row_pos <= '0;
        end else begin
          row_pos <= row_pos + pos_t'(1);
        end
      end
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos   <= row_pos;
      s1_value <= s_tdata;
    end
  end

  // letterbox undo: exact difference, then magnitude times reciprocal scale
  assign s1_diff = {s1_value[31], s1_value} - {5'd0, (s1_pos[0] ? offset_y : offset_x)};
  assign s1_neg  = s1_diff[32];
  assign s1_mag  = s1_neg ? 32'(-s1_diff) : s1_diff[31:0];
  assign s1_prod = s1_mag * inverse_scale;

  always_ff @(posedge clk) begin
    s2_pos   <= s1_pos;
    s2_value <= s1_value;
    s2_neg   <= s1_neg;
    s2_prod  <= s1_prod;
  end

  // truncate toward zero, then saturate to 32 bits
  assign s2_p = s2_prod[PROD_W-1:16];

  always_comb begin
    if (s2_neg) begin
      if (s2_p > 40'h00_8000_0000) begin
        coord = 32'h8000_0000;
      end else begin
        coord = ~s2_p[31:0] + 32'd1;
      end
    end else begin
      if (s2_p > 40'h00_7FFF_FFFF) begin
        coord = 32'h7FFF_FFFF;
      end else begin
        coord = s2_p[31:0];
      end
    end
  end

  assign is_y = s2_pos[0];

  assign color_zone  = s2_pos >= pos_t'(COLOR_POS) && s2_pos < pos_t'(NUMBER_POS);
  assign color_take  = color_zone && (s2_pos == pos_t'(COLOR_POS) ||
                       $signed(s2_value) > $signed(best_color_score));
  assign number_zone = s2_pos >= pos_t'(NUMBER_POS);
  assign number_take = number_zone && (s2_pos == pos_t'(NUMBER_POS) ||
                       $signed(s2_value) > $signed(best_number_score));

  always_comb begin
    number_score_next = best_number_score;
    number_index_next = best_number_index;
    if (number_take) begin
      number_score_next = s2_value;
      number_index_next = NIDX_W'(s2_pos - pos_t'(NUMBER_POS));
    end
  end

  // a negative confidence is always below the threshold
  assign row_end = s2_valid && s2_pos == LAST_POS;
  assign keep    = !candidate_score[31] &&
                   candidate_score >= {15'd0, score_threshold} &&
                   best_color_index == CIDX_W'(select_blue);

  always_ff @(posedge clk) begin
    if (s2_valid && s2_pos < pos_t'(POINT_VALUES)) begin
      point_store[s2_pos[2:0]] <= coord;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_pos < pos_t'(POINT_VALUES)) begin
      if (s2_pos < pos_t'(2)) begin
        if (is_y) begin
          box_top    <= coord;
          box_bottom <= coord;
        end else begin
          box_left   <= coord;
          box_right  <= coord;
        end
      end else if (is_y) begin
        if ($signed(coord) < $signed(box_top))    box_top    <= coord;
        if ($signed(coord) > $signed(box_bottom)) box_bottom <= coord;
      end else begin
        if ($signed(coord) < $signed(box_left))   box_left   <= coord;
        if ($signed(coord) > $signed(box_right))  box_right  <= coord;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      candidate_score   <= '0;
      best_color_score  <= '0;
      best_color_index  <= '0;
      best_number_score <= '0;
      best_number_index <= '0;
    end else if (s2_valid) begin
      if (s2_pos == pos_t'(SCORE_POS)) begin
        candidate_score <= s2_value;
      end
      if (color_take) begin
        best_color_score <= s2_value;
        best_color_index <= CIDX_W'(s2_pos - pos_t'(COLOR_POS));
      end
      best_number_score <= number_score_next;
      best_number_index <= number_index_next;
    end
  end

  // result buffer: one kept candidate, sent as four items
  always_ff @(posedge clk) begin
    if (row_end && keep) begin
      o_pt     <= point_store;
      o_left   <= box_left;
      o_top    <= box_top;
      o_right  <= box_right;
      o_bottom <= box_bottom;
      o_score  <= candidate_score;
      o_color  <= best_color_index[0];
      o_nclass <= number_index_next;
      o_nscore <= number_score_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy <= 1'b0;
      out_idx  <= '0;
    end else if (row_end && keep) begin
      out_busy <= 1'b1;
      out_idx  <= '0;
    end else if (m_tvalid && m_tready) begin
      if (out_idx == 2'd3) begin
        out_busy <= 1'b0;
      end
      out_idx <= out_idx + 2'd1;
    end
  end

  assign m_tvalid = out_busy;
  assign m_tuser  = out_idx;
  assign m_tlast  = out_idx == 2'd3;
  assign m_tdata  = {3'd0, o_bottom, o_right, o_top, o_left, o_nscore, o_nclass, o_color,
                     o_score, o_pt[{out_idx, 1'b1}], o_pt[{out_idx, 1'b0}]};

endmodule
